FILE: sv/shape_collision_test_unit_macros.svh
// Assertion helpers for the shape collision test unit.
`ifndef SHAPE_COLLISION_TEST_UNIT_MACROS_SVH
`define SHAPE_COLLISION_TEST_UNIT_MACROS_SVH

// Checked at every rising edge, muted while reset is held.
`define SCT_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("sct assertion failed");

// Checked at every rising edge, reset included.
`define SCT_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("sct assertion failed");

`endif

FILE: sv/sct_pkg.sv
package sct_pkg;

	localparam int CMD_BITS = 3;
	localparam int OUT_BITS = 8;
	localparam int NSTG     = 4;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_POINT_BOX     = 3'd0,
		CMD_BOX_BOX       = 3'd1,
		CMD_BOX_CIRCLE    = 3'd2,
		CMD_CIRCLE_CIRCLE = 3'd3,
		CMD_POINT_CIRCLE  = 3'd4
	} cmd_t;

	// per-stage pipeline control
	typedef struct packed {
		logic [NSTG-1:0] vld;  // stage holds a transaction
		logic [NSTG-1:0] ld;   // stage registers load this cycle
	} ctl_t;

endpackage

FILE: sv/sct_pipe_ctl.sv
module sct_pipe_ctl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          out_ready,
	output sct_pkg::ctl_t ctl
);

	logic [sct_pkg::NSTG-1:0] stage_vld_q;
	logic [sct_pkg::NSTG:0]   rdy;
	logic [sct_pkg::NSTG-1:0] ld;

	// a stage can take new data when empty or when it drains this cycle
	always_comb begin
		rdy[sct_pkg::NSTG] = out_ready;
		for (int i = sct_pkg::NSTG - 1; i >= 0; i--) begin
			rdy[i] = !stage_vld_q[i] || rdy[i+1];
		end
		ld[0] = in_valid && rdy[0];
		for (int i = 1; i < sct_pkg::NSTG; i++) begin
			ld[i] = stage_vld_q[i-1] && rdy[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				stage_vld_q[0] <= in_valid;
			end
			for (int i = 1; i < sct_pkg::NSTG; i++) begin
				if (rdy[i]) begin
					stage_vld_q[i] <= stage_vld_q[i-1];
				end
			end
		end
	end

	assign in_ready = rdy[0];
	assign ctl.vld  = stage_vld_q;
	assign ctl.ld   = ld;

endmodule

FILE: sv/shape_collision_test_unit.sv
// Shape collision test unit: one overlap test per input transaction, one
// result transaction per test.
// Input channel s_axis_*: tuser carries the test code (point-box, box-box,
// box-circle, circle-circle, point-circle); tdata carries eight signed
// COORD_BITS coordinates (a_x0, a_y0, a_x1, a_y1, b_x0, b_y0, b_x1, b_y1).
// Output channel m_axis_*: tdata bit 0 is the collide flag, rest zero.
// A result passes through four registered stages (difference, magnitude,
// square, and sum-and-compare) before it is presented on m_axis_*.
// Throughput: one test per cycle while m_axis_tready stays high; a stage
// advances only when the stage after it can take its data.
// Reset (arst_n low, asynchronous) empties the pipeline; the data path
// registers are not reset.
// When the receiver stalls, the result stays on m_axis_* and stages behind
// it keep filling bubbles; s_axis_tready drops only when all four stages
// are full and m_axis_tready is low. Nothing is lost or repeated.
module shape_collision_test_unit #(
	parameter int COORD_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// a_x0, a_y0, a_x1, a_y1, b_x0, b_y0, b_x1, b_y1 (from bit 0 up)
	input  logic [8*COORD_BITS-1:0]             s_axis_tdata,
	// command
	input  logic [sct_pkg::CMD_BITS-1:0]        s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// colliding, then zero fill
	output logic [sct_pkg::OUT_BITS-1:0]        m_axis_tdata
);

	localparam int C = COORD_BITS;
	localparam int W = COORD_BITS + 1;   // differences and sums

	sct_pkg::ctl_t ctl;

	sct_pipe_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_ready (m_axis_tready),
		.ctl       (ctl)
	);

	// ---------------- stage 1: compares, differences, test select
	logic signed [C-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
	logic signed [W-1:0] ax0e, ay0e, ax1e, ay1e, bx0e, by0e, bx1e;
	logic signed [W-1:0] dx, dy, gx, gy, rs;
	logic signed [W-1:0] ex_d, ey_d, r_d;
	logic                hit_pb, hit_bb, circ_d, flag_d;
	sct_pkg::cmd_t       cmd;

	assign ax0 = s_axis_tdata[0*C +: C];
	assign ay0 = s_axis_tdata[1*C +: C];
	assign ax1 = s_axis_tdata[2*C +: C];
	assign ay1 = s_axis_tdata[3*C +: C];
	assign bx0 = s_axis_tdata[4*C +: C];
	assign by0 = s_axis_tdata[5*C +: C];
	assign bx1 = s_axis_tdata[6*C +: C];
	assign by1 = s_axis_tdata[7*C +: C];

	assign ax0e = {ax0[C-1], ax0};
	assign ay0e = {ay0[C-1], ay0};
	assign ax1e = {ax1[C-1], ax1};
	assign ay1e = {ay1[C-1], ay1};
	assign bx0e = {bx0[C-1], bx0};
	assign by0e = {by0[C-1], by0};
	assign bx1e = {bx1[C-1], bx1};

	assign cmd = sct_pkg::cmd_t'(s_axis_tuser);

	// inclusive compares, boxes taken as written even when inverted
	assign hit_pb = (ax0 >= bx0) && (ax0 <= bx1) && (ay0 >= by0) && (ay0 <= by1);
	assign hit_bb = !((ax1 < bx0) || (ax0 > bx1) || (ay1 < by0) || (ay0 > by1));

	assign dx = ax0e - bx0e;
	assign dy = ay0e - by0e;
	assign rs = ax1e + bx1e;

	// gap from circle center to box a along each axis, always >= 0
	always_comb begin
		if (bx0 < ax0) begin
			gx = ax0e - bx0e;
		end else if (bx0 > ax1) begin
			gx = bx0e - ax1e;
		end else begin
			gx = '0;
		end
		if (by0 < ay0) begin
			gy = ay0e - by0e;
		end else if (by0 > ay1) begin
			gy = by0e - ay1e;
		end else begin
			gy = '0;
		end
	end

	// flag_d: final hit for box tests, radius-valid gate for circle tests
	always_comb begin
		circ_d = 1'b0;
		flag_d = 1'b0;
		ex_d   = dx;
		ey_d   = dy;
		r_d    = bx1e;
		unique case (cmd)
			sct_pkg::CMD_POINT_BOX: begin
				flag_d = hit_pb;
			end
			sct_pkg::CMD_BOX_BOX: begin
				flag_d = hit_bb;
			end
			sct_pkg::CMD_BOX_CIRCLE: begin
				circ_d = 1'b1;
				flag_d = 1'b1;   // radius acts as its magnitude
				ex_d   = gx;
				ey_d   = gy;
			end
			sct_pkg::CMD_CIRCLE_CIRCLE: begin
				circ_d = 1'b1;
				flag_d = !rs[W-1];
				r_d    = rs;
			end
			sct_pkg::CMD_POINT_CIRCLE: begin
				circ_d = 1'b1;
				flag_d = !bx1[C-1];
			end
			default: begin
				flag_d = 1'b0;   // unknown code never collides
			end
		endcase
	end

	logic signed [W-1:0] ex_s1, ey_s1, r_s1;
	logic                circ_s1, flag_s1;

	always_ff @(posedge clk) begin
		if (ctl.ld[0]) begin
			ex_s1   <= ex_d;
			ey_s1   <= ey_d;
			r_s1    <= r_d;
			circ_s1 <= circ_d;
			flag_s1 <= flag_d;
		end
	end

	// ---------------- stage 2: magnitudes
	function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
		mag = v[W-1] ? (~v + 1'b1) : v;
	endfunction

	logic [W-1:0] mx_s2, my_s2, mr_s2;
	logic         circ_s2, flag_s2;

	always_ff @(posedge clk) begin
		if (ctl.ld[1]) begin
			mx_s2   <= mag(ex_s1);
			my_s2   <= mag(ey_s1);
			mr_s2   <= mag(r_s1);
			circ_s2 <= circ_s1;
			flag_s2 <= flag_s1;
		end
	end

	// ---------------- stage 3: exact squares
	logic [2*W-1:0] sx_s3, sy_s3, sr_s3;
	logic           circ_s3, flag_s3;

	always_ff @(posedge clk) begin
		if (ctl.ld[2]) begin
			sx_s3   <= mx_s2 * mx_s2;
			sy_s3   <= my_s2 * my_s2;
			sr_s3   <= mr_s2 * mr_s2;
			circ_s3 <= circ_s2;
			flag_s3 <= flag_s2;
		end
	end

	// ---------------- stage 4: sum, compare, output register
	logic [2*W:0] d2;
	logic         in_range, hit_d;
	logic         colliding_s4;

	assign d2       = {1'b0, sx_s3} + {1'b0, sy_s3};
	assign in_range = d2 <= {1'b0, sr_s3};
	assign hit_d    = circ_s3 ? (flag_s3 && in_range) : flag_s3;

	always_ff @(posedge clk) begin
		if (ctl.ld[3]) begin
			colliding_s4 <= hit_d;
		end
	end

	assign m_axis_tvalid = ctl.vld[sct_pkg::NSTG-1];
	assign m_axis_tdata  = {{(sct_pkg::OUT_BITS-1){1'b0}}, colliding_s4};

endmodule

FILE: sv/sct_checker.sv
`include "shape_collision_test_unit_macros.svh"

module sct_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_axis_tvalid,
	input logic                         s_axis_tready,
	input logic                         m_axis_tvalid,
	input logic                         m_axis_tready,
	input logic [sct_pkg::OUT_BITS-1:0] m_axis_tdata
);

	// a stalled result holds
	`SCT_ASSERT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

	// only the collide bit may be set
	`SCT_ASSERT(a_out_pad, clk, arst_n, m_axis_tvalid |-> m_axis_tdata[sct_pkg::OUT_BITS-1:1] == '0)

	// an accepted test must be followed by a valid output at the pipeline depth
	`SCT_ASSERT(a_latency, clk, arst_n, s_axis_tvalid && s_axis_tready |-> ##4 m_axis_tvalid)

	// reset empties the pipeline by the next edge
	`SCT_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |=> !m_axis_tvalid)

endmodule

bind shape_collision_test_unit sct_checker u_sct_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
